// ===== rtl/core/gsng_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsng_pkg
// Shared types, widths and stencil tables of the grid stencil neighbor
// generator.
// ---------------------------------------------------------------------------
package gsng_pkg;

  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int IDX_W   = 30;
  localparam int EDGE_W  = 35;
  localparam int ROW_W   = 22;   // y + ny*z
  localparam int PYZ_W   = 21;   // ny*z
  localparam int SZ_W    = 22;   // nx*ny
  localparam int OFS_W   = 5;    // offset table index

  localparam int MAX_DIM_DEF     = 1024;
  localparam int MAX_STENCIL_DEF = 26;

  localparam int STENCIL6_LEN  = 6;
  localparam int STENCIL26_LEN = 26;

  // per-axis step codes
  localparam logic [1:0] STEP_ZER = 2'b00;
  localparam logic [1:0] STEP_POS = 2'b01;
  localparam logic [1:0] STEP_NEG = 2'b11;

  typedef struct packed {
    logic [1:0] dz;
    logic [1:0] dy;
    logic [1:0] dx;
  } off_t;

  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               start_grid;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  neighbor_index;
    logic [EDGE_W-1:0] edge_position;
    logic              has_neighbor;
    logic              coord_error;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim_x;
    logic [DIM_W-1:0] dim_y;
    logic [DIM_W-1:0] dim_z;
    logic             stencil_mode;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic calc1;
    logic calc2;
    logic advance;
    logic emit_nb;
    logic emit_empty;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic mask_empty;
    logic cur_valid;
    logic cur_last;
    logic out_free;
  } sts_t;

  // 26-cell stencil: dz outer, dy, dx inner, center skipped
  localparam off_t OFF26 [STENCIL26_LEN] = '{
    {STEP_NEG, STEP_NEG, STEP_NEG}, {STEP_NEG, STEP_NEG, STEP_ZER},
    {STEP_NEG, STEP_NEG, STEP_POS}, {STEP_NEG, STEP_ZER, STEP_NEG},
    {STEP_NEG, STEP_ZER, STEP_ZER}, {STEP_NEG, STEP_ZER, STEP_POS},
    {STEP_NEG, STEP_POS, STEP_NEG}, {STEP_NEG, STEP_POS, STEP_ZER},
    {STEP_NEG, STEP_POS, STEP_POS},
    {STEP_ZER, STEP_NEG, STEP_NEG}, {STEP_ZER, STEP_NEG, STEP_ZER},
    {STEP_ZER, STEP_NEG, STEP_POS}, {STEP_ZER, STEP_ZER, STEP_NEG},
    {STEP_ZER, STEP_ZER, STEP_POS}, {STEP_ZER, STEP_POS, STEP_NEG},
    {STEP_ZER, STEP_POS, STEP_ZER}, {STEP_ZER, STEP_POS, STEP_POS},
    {STEP_POS, STEP_NEG, STEP_NEG}, {STEP_POS, STEP_NEG, STEP_ZER},
    {STEP_POS, STEP_NEG, STEP_POS}, {STEP_POS, STEP_ZER, STEP_NEG},
    {STEP_POS, STEP_ZER, STEP_ZER}, {STEP_POS, STEP_ZER, STEP_POS},
    {STEP_POS, STEP_POS, STEP_NEG}, {STEP_POS, STEP_POS, STEP_ZER},
    {STEP_POS, STEP_POS, STEP_POS}
  };

  // face stencil: -x, +x, -y, +y, -z, +z
  localparam off_t OFF6 [STENCIL6_LEN] = '{
    {STEP_ZER, STEP_ZER, STEP_NEG}, {STEP_ZER, STEP_ZER, STEP_POS},
    {STEP_ZER, STEP_NEG, STEP_ZER}, {STEP_ZER, STEP_POS, STEP_ZER},
    {STEP_NEG, STEP_ZER, STEP_ZER}, {STEP_POS, STEP_ZER, STEP_ZER}
  };

  function automatic off_t offset_at(input logic mode, input logic [OFS_W-1:0] idx);
    off_t o;
    o = '0;
    if (mode) begin
      if (idx < OFS_W'(STENCIL26_LEN)) o = OFF26[idx];
    end else begin
      if (idx < OFS_W'(STENCIL6_LEN)) o = OFF6[idx[2:0]];
    end
    return o;
  endfunction

  // signed step of a 30-bit stride
  function automatic logic [IDX_W-1:0] step_term(input logic [1:0] code,
                                                  input logic [IDX_W-1:0] stride);
    logic [IDX_W-1:0] t;
    t = '0;
    if (code == STEP_POS) t = stride;
    else if (code == STEP_NEG) t = IDX_W'(0) - stride;
    return t;
  endfunction

  // step allowed on an axis given the boundary flags
  function automatic logic step_ok(input logic [1:0] code, input logic can_neg,
                                   input logic can_pos);
    logic ok;
    ok = 1'b1;
    if (code == STEP_POS) ok = can_pos;
    else if (code == STEP_NEG) ok = can_neg;
    return ok;
  endfunction

endpackage

// ===== rtl/core/gsng_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsng_regs
// APB register file: grid dimensions and stencil mode.
// ---------------------------------------------------------------------------
module gsng_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gsng_pkg::cfg_t     cfg
);

  localparam logic [1:0] REG_DIM_X = 2'd0;
  localparam logic [1:0] REG_DIM_Y = 2'd1;
  localparam logic [1:0] REG_DIM_Z = 2'd2;
  localparam logic [1:0] REG_MODE  = 2'd3;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_x        <= gsng_pkg::DIM_W'(1);
      cfg.dim_y        <= gsng_pkg::DIM_W'(1);
      cfg.dim_z        <= gsng_pkg::DIM_W'(1);
      cfg.stencil_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DIM_X: cfg.dim_x <= pwdata[gsng_pkg::DIM_W-1:0];
        REG_DIM_Y: cfg.dim_y <= pwdata[gsng_pkg::DIM_W-1:0];
        REG_DIM_Z: cfg.dim_z <= pwdata[gsng_pkg::DIM_W-1:0];
        REG_MODE:  cfg.stencil_mode <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIM_X: prdata = 32'(cfg.dim_x);
      REG_DIM_Y: prdata = 32'(cfg.dim_y);
      REG_DIM_Z: prdata = 32'(cfg.dim_z);
      REG_MODE:  prdata = 32'(cfg.stencil_mode);
    endcase
  end

endmodule

// ===== rtl/core/gsng_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsng_ctrl
// Sequencer: index setup, stencil scan and result emission per cell.
// ---------------------------------------------------------------------------
module gsng_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gsng_pkg::sts_t  sts,
  output gsng_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC1,
    S_CALC2,
    S_SCAN,
    S_EMPTY,
    S_ERR
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CALC1;
        end
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = sts.range_ok ? S_CALC2 : S_ERR;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = sts.mask_empty ? S_EMPTY : S_SCAN;
      end
      S_SCAN: begin
        if (!sts.cur_valid) begin
          cmd.advance = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_nb = 1'b1;
          if (sts.cur_last) state_next = S_IDLE;
          else cmd.advance = 1'b1;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== rtl/core/gsng_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsng_dp
// Datapath: cell registers, index multipliers, neighbor mask, edge count
// and output register.
// ---------------------------------------------------------------------------
module gsng_dp #(
  parameter int MAX_DIM     = gsng_pkg::MAX_DIM_DEF,
  parameter int MAX_STENCIL = gsng_pkg::MAX_STENCIL_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  gsng_pkg::cfg_t  cfg,
  input  gsng_pkg::in_t   in_data,
  input  gsng_pkg::cmd_t  cmd,
  output gsng_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_stall,
  output gsng_pkg::out_t  out_data
);

  localparam int DIM_FULL = (1 << gsng_pkg::DIM_W) - 1;
  localparam logic [gsng_pkg::DIM_W-1:0] DIM_CAP =
    (MAX_DIM > DIM_FULL) ? gsng_pkg::DIM_W'(DIM_FULL) : gsng_pkg::DIM_W'(MAX_DIM);
  localparam int IW = (MAX_STENCIL > 1) ? $clog2(MAX_STENCIL) : 1;

  logic [gsng_pkg::COORD_W-1:0] cx, cy, cz;
  logic [gsng_pkg::DIM_W-1:0]   nx, ny, nz;
  logic [gsng_pkg::PYZ_W-1:0]   prod_yz;
  logic [gsng_pkg::SZ_W-1:0]    stride_z;
  logic [gsng_pkg::IDX_W-1:0]   node;
  logic [gsng_pkg::ROW_W-1:0]   row;
  logic [32:0]                  node_full;
  logic [MAX_STENCIL-1:0]       mask_reg, mask_next;
  logic [IW-1:0]                idx;
  logic [gsng_pkg::EDGE_W-1:0]  edge_total;
  logic                         can_xn, can_xp, can_yn, can_yp, can_zn, can_zp;
  gsng_pkg::off_t               cur_off;
  logic [gsng_pkg::IDX_W-1:0]   nb_index;
  logic                         load;

  assign nx = (cfg.dim_x > DIM_CAP) ? DIM_CAP : cfg.dim_x;
  assign ny = (cfg.dim_y > DIM_CAP) ? DIM_CAP : cfg.dim_y;
  assign nz = (cfg.dim_z > DIM_CAP) ? DIM_CAP : cfg.dim_z;

  // boundary flags of the held cell
  assign can_xn = (cx != '0);
  assign can_yn = (cy != '0);
  assign can_zn = (cz != '0);
  assign can_xp = ((gsng_pkg::DIM_W'(cx) + 1'b1) < nx);
  assign can_yp = ((gsng_pkg::DIM_W'(cy) + 1'b1) < ny);
  assign can_zp = ((gsng_pkg::DIM_W'(cz) + 1'b1) < nz);

  always_comb begin
    gsng_pkg::off_t o;
    logic in_len;
    mask_next = '0;
    for (int i = 0; i < MAX_STENCIL; i++) begin
      o      = gsng_pkg::offset_at(cfg.stencil_mode, gsng_pkg::OFS_W'(i));
      in_len = cfg.stencil_mode ? (i < gsng_pkg::STENCIL26_LEN)
                                : (i < gsng_pkg::STENCIL6_LEN);
      mask_next[i] = in_len && gsng_pkg::step_ok(o.dx, can_xn, can_xp)
                            && gsng_pkg::step_ok(o.dy, can_yn, can_yp)
                            && gsng_pkg::step_ok(o.dz, can_zn, can_zp);
    end
  end

  assign row       = gsng_pkg::ROW_W'(cy) + gsng_pkg::ROW_W'(prod_yz);
  assign node_full = 33'(cx) + 33'(nx) * 33'(row);

  assign cur_off  = gsng_pkg::offset_at(cfg.stencil_mode, gsng_pkg::OFS_W'(idx));
  assign nb_index = node
                  + gsng_pkg::step_term(cur_off.dx, gsng_pkg::IDX_W'(1))
                  + gsng_pkg::step_term(cur_off.dy, gsng_pkg::IDX_W'(nx))
                  + gsng_pkg::step_term(cur_off.dz, gsng_pkg::IDX_W'(stride_z));

  assign sts.range_ok   = (gsng_pkg::DIM_W'(cx) < nx) && (gsng_pkg::DIM_W'(cy) < ny)
                       && (gsng_pkg::DIM_W'(cz) < nz);
  assign sts.mask_empty = (mask_reg == '0);
  assign sts.cur_valid  = mask_reg[idx];
  assign sts.cur_last   = (((mask_reg >> idx) >> 1) == '0);
  assign sts.out_free   = !out_valid || !out_stall;

  assign load = cmd.emit_nb || cmd.emit_empty || cmd.emit_err;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cx <= in_data.coord_x;
      cy <= in_data.coord_y;
      cz <= in_data.coord_z;
    end
    if (cmd.calc1) begin
      prod_yz  <= gsng_pkg::PYZ_W'(ny) * gsng_pkg::PYZ_W'(cz);
      stride_z <= gsng_pkg::SZ_W'(nx) * gsng_pkg::SZ_W'(ny);
      mask_reg <= mask_next;
    end
    if (cmd.calc2) node <= node_full[gsng_pkg::IDX_W-1:0];
    if (cmd.accept) idx <= '0;
    else if (cmd.advance) idx <= idx + 1'b1;

    if (cmd.emit_nb) begin
      out_data.node_index     <= node;
      out_data.neighbor_index <= nb_index;
      out_data.edge_position  <= edge_total;
      out_data.has_neighbor   <= 1'b1;
      out_data.coord_error    <= 1'b0;
      out_data.last           <= sts.cur_last;
    end else if (cmd.emit_empty) begin
      out_data.node_index     <= node;
      out_data.neighbor_index <= '0;
      out_data.edge_position  <= edge_total;
      out_data.has_neighbor   <= 1'b0;
      out_data.coord_error    <= 1'b0;
      out_data.last           <= 1'b1;
    end else if (cmd.emit_err) begin
      out_data.node_index     <= '0;
      out_data.neighbor_index <= '0;
      out_data.edge_position  <= edge_total;
      out_data.has_neighbor   <= 1'b0;
      out_data.coord_error    <= 1'b1;
      out_data.last           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept && in_data.start_grid) edge_total <= '0;
      else if (cmd.emit_nb) edge_total <= edge_total + 1'b1;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/grid_stencil_neighbor_generator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_stencil_neighbor_generator
// Emits the in-bounds stencil neighbors of a 3D grid cell in CSR order.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one cell coordinate and a
//   start flag that clears the running edge count. Output channel
//   (out_valid/out_stall/out_data) gives one transaction per in-bounds
//   neighbor, the final one flagged last; a cell without neighbors or with an
//   out-of-range coordinate gives a single flagged transaction.
//   Grid dimensions and stencil mode are set over the APB port while idle.
// Timing:
//   Per in-range cell the setup states CALC1 (index multiplies, neighbor
//   mask) and CALC2 (node index) run first, then the stencil scan handles
//   one offset per cycle up to the last valid one, waiting on a valid one
//   while the output register is held. An out-of-range coordinate goes
//   from CALC1 to the error state, which loads its single flagged result.
//   The next cell is taken in the cycle after the last result is loaded into
//   the output register.
// Reset: rst clears sequencer, output valid, edge count; dims reset to 1.
// Stall: out_stall holds the output register; the scan waits on it.
// ---------------------------------------------------------------------------
module grid_stencil_neighbor_generator #(
  parameter int MAX_DIM     = gsng_pkg::MAX_DIM_DEF,
  parameter int MAX_STENCIL = gsng_pkg::MAX_STENCIL_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gsng_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output gsng_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  gsng_pkg::cfg_t cfg;
  gsng_pkg::cmd_t cmd;
  gsng_pkg::sts_t sts;

  gsng_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsng_dp #(
    .MAX_DIM     (MAX_DIM),
    .MAX_STENCIL (MAX_STENCIL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/gsng_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsng_checker
// Port-level checks of the neighbor generator, bound to the top level.
// ---------------------------------------------------------------------------
module gsng_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input gsng_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_stall,
  input gsng_pkg::out_t  out_data
);

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // setup takes cycles, so a cell is never followed by another right away
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during setup");

  a_flagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!out_data.has_neighbor || out_data.coord_error)
      |-> out_data.last && !(out_data.has_neighbor && out_data.coord_error))
    else $error("flagged result not last");

endmodule

bind grid_stencil_neighbor_generator gsng_checker u_chk (.*);

// ===== tb/sv/gsng_neighbor_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gsng_neighbor_checker
// Watches the coordinate, neighbor and register channels of the grid stencil
// neighbor generator, expands every accepted coordinate into its expected
// neighbor transactions and compares them in order with what comes out.
// ---------------------------------------------------------------------------
package gsng_tb_pkg;

  typedef enum logic [3:0] {
    REG_DIM_X = 4'h0,
    REG_DIM_Y = 4'h4,
    REG_DIM_Z = 4'h8,
    REG_MODE  = 4'hC
  } reg_addr_e;

  localparam logic MODE_FACE6  = 1'b0;
  localparam logic MODE_CUBE26 = 1'b1;

endpackage

module gsng_neighbor_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  gsng_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  gsng_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           pready,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output int             fail_count,
  output int             pending,
  output int             checked
);
  import gsng_pkg::*;
  import gsng_tb_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [DIM_W-1:0]  dim_x;
  logic [DIM_W-1:0]  dim_y;
  logic [DIM_W-1:0]  dim_z;
  logic              stencil_mode;
  logic [EDGE_W-1:0] edge_count;
  out_t              nbr_expect_q[$];

  function automatic longint unsigned clamp_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM_DEF) ? longint'(MAX_DIM_DEF) : longint'(d);
  endfunction

  // one axis move, fails when the neighbor leaves [0, n)
  function automatic bit axis_step(input longint unsigned c, input int d,
                                   input longint unsigned n,
                                   output longint unsigned res);
    res = c;
    if (d < 0) begin
      if (c == 0) return 1'b0;
      res = c - 1;
    end else if (d > 0) begin
      if (c + 1 >= n) return 1'b0;
      res = c + 1;
    end
    return 1'b1;
  endfunction

  // append one expected transaction at the tail
  function automatic void expect_result(input out_t r);
    nbr_expect_q.insert(nbr_expect_q.size(), r);
  endfunction

  function automatic void expand_cell(input in_t crd);
    longint unsigned nx, ny, nz, x, y, z, node, px, py, pz;
    int   n_off, i, j, dx, dy, dz;
    bit   ok, have_prev;
    out_t r, prev;
    nx = clamp_dim(dim_x);
    ny = clamp_dim(dim_y);
    nz = clamp_dim(dim_z);
    x  = crd.coord_x;
    y  = crd.coord_y;
    z  = crd.coord_z;
    if (crd.start_grid) edge_count = '0;
    r = '0;
    r.edge_position = edge_count;
    r.last = 1'b1;
    if (x >= nx || y >= ny || z >= nz) begin
      r.coord_error = 1'b1;
      expect_result(r);
      return;
    end
    node = x + nx * (y + ny * z);
    r.node_index = IDX_W'(node);
    n_off = (stencil_mode == MODE_CUBE26) ? STENCIL26_LEN : STENCIL6_LEN;
    if (n_off > MAX_STENCIL_DEF) n_off = MAX_STENCIL_DEF;
    have_prev = 1'b0;
    prev = '0;
    for (i = 0; i < n_off; i++) begin
      if (stencil_mode == MODE_CUBE26) begin
        j  = (i >= 13) ? i + 1 : i;   // center is not a neighbor
        dx = (j % 3) - 1;
        dy = ((j / 3) % 3) - 1;
        dz = (j / 9) - 1;
      end else begin
        dx = (i / 2 == 0) ? ((i % 2 == 1) ? 1 : -1) : 0;
        dy = (i / 2 == 1) ? ((i % 2 == 1) ? 1 : -1) : 0;
        dz = (i / 2 == 2) ? ((i % 2 == 1) ? 1 : -1) : 0;
      end
      ok = axis_step(x, dx, nx, px);
      if (ok) ok = axis_step(y, dy, ny, py);
      if (ok) ok = axis_step(z, dz, nz, pz);
      if (ok) begin
        if (have_prev) expect_result(prev);
        prev = r;
        prev.neighbor_index = IDX_W'(px + nx * (py + ny * pz));
        prev.edge_position  = edge_count;
        prev.has_neighbor   = 1'b1;
        prev.last           = 1'b0;
        have_prev  = 1'b1;
        edge_count = edge_count + 1'b1;
      end
    end
    if (have_prev) begin
      prev.last = 1'b1;
      expect_result(prev);
    end else begin
      expect_result(r);
    end
  endfunction

  function automatic void check_result(input out_t got);
    out_t exp_r;
    bit   bad;
    checked++;
    if (nbr_expect_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected transaction node %0h nb %0h pos %0h has %0b err %0b last %0b",
                 $time, got.node_index, got.neighbor_index, got.edge_position,
                 got.has_neighbor, got.coord_error, got.last);
      return;
    end
    exp_r = nbr_expect_q.pop_front();
    bad = (got.node_index     != exp_r.node_index)     ||
          (got.neighbor_index != exp_r.neighbor_index) ||
          (got.edge_position  != exp_r.edge_position)  ||
          (got.has_neighbor   != exp_r.has_neighbor)   ||
          (got.coord_error    != exp_r.coord_error)    ||
          (got.last           != exp_r.last);
    if (bad) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: mismatch (expected / actual)", $time);
        $display("  node %0h / %0h  nb %0h / %0h  pos %0h / %0h",
                 exp_r.node_index, got.node_index, exp_r.neighbor_index,
                 got.neighbor_index, exp_r.edge_position, got.edge_position);
        $display("  has %0b / %0b  err %0b / %0b  last %0b / %0b",
                 exp_r.has_neighbor, got.has_neighbor, exp_r.coord_error,
                 got.coord_error, exp_r.last, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dim_x        = DIM_W'(1);
      dim_y        = DIM_W'(1);
      dim_z        = DIM_W'(1);
      stencil_mode = MODE_FACE6;
      edge_count   = '0;
      nbr_expect_q.delete();
      fail_count   = 0;
      checked      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_DIM_X: dim_x = pwdata[DIM_W-1:0];
          REG_DIM_Y: dim_y = pwdata[DIM_W-1:0];
          REG_DIM_Z: dim_z = pwdata[DIM_W-1:0];
          REG_MODE:  stencil_mode = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) expand_cell(in_data);
    end
    pending = nbr_expect_q.size();
  end

endmodule

// ===== tb/sv/grid_stencil_neighbor_generator_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_stencil_neighbor_generator_test
// Drives coordinates and register settings into the neighbor generator:
// a directed pass over corners, centers, capped and empty grids, then random
// CSR-style sweeps and stray coordinates under several grid settings, with
// random gaps and output stalls. The checker does the comparison.
// ---------------------------------------------------------------------------
module grid_stencil_neighbor_generator_test;
  import gsng_pkg::*;
  import gsng_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int N_PHASES      = 10;
  localparam int PHASE_ITEMS   = 26;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 18;
  localparam int CALM_PHASE    = 4;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm      = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int n_settings = 0;
  int cycle_cnt  = 0;
  int unsigned nx_eff = 1;
  int unsigned ny_eff = 1;
  int unsigned nz_eff = 1;

  grid_stencil_neighbor_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  gsng_neighbor_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d transactions outstanding", cycle_cnt, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return MAX_DIM_DEF;
    if (r == 2) return 2047;
    if (r == 3) return $urandom_range(MAX_DIM_DEF + 1, 2047);
    if (r <= 5) return $urandom_range(1, 2047);
    return $urandom_range(1, 6);
  endfunction

  // boundary-biased coordinate; anything goes on an empty axis
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (n == 0) return COORD_W'($urandom_range(0, 1023));
    if (r < 2) return '0;
    if (r < 4) return COORD_W'(n - 1);
    return COORD_W'($urandom_range(0, n - 1));
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input int unsigned nx, input int unsigned ny,
                              input int unsigned nz, input logic mode);
    reg_addr_e   addrs[4];
    int unsigned vals[4];
    int          i;
    addrs = '{REG_DIM_X, REG_DIM_Y, REG_DIM_Z, REG_MODE};
    vals  = '{nx, ny, nz, int'(mode)};
    wait_drained();
    for (i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addrs[i];
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      while (!pready) @(negedge clk);
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    nx_eff = (nx > MAX_DIM_DEF) ? MAX_DIM_DEF : nx;
    ny_eff = (ny > MAX_DIM_DEF) ? MAX_DIM_DEF : ny;
    nz_eff = (nz > MAX_DIM_DEF) ? MAX_DIM_DEF : nz;
    n_settings++;
  endtask

  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic start);
    in_t c;
    c.coord_x    = x;
    c.coord_y    = y;
    c.coord_z    = z;
    c.start_grid = start;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // consecutive cells in linear order, as when building one CSR row block
  task automatic run_sweep(input int len);
    logic [COORD_W-1:0] x, y, z;
    int i;
    x = pick_coord(nx_eff);
    y = pick_coord(ny_eff);
    z = pick_coord(nz_eff);
    for (i = 0; i < len; i++) begin
      send_coord(x, y, z, (i == 0) && ($urandom_range(0, 4) != 0));
      if (nx_eff == 0 || ny_eff == 0 || nz_eff == 0 ||
          x >= nx_eff || y >= ny_eff || z >= nz_eff) begin
        x = pick_coord(nx_eff);
        y = pick_coord(ny_eff);
        z = pick_coord(nz_eff);
      end else if (int'(x) + 1 < nx_eff) begin
        x = x + 1'b1;
      end else begin
        x = '0;
        if (int'(y) + 1 < ny_eff) begin
          y = y + 1'b1;
        end else begin
          y = '0;
          z = (int'(z) + 1 < nz_eff) ? z + 1'b1 : '0;
        end
      end
    end
  endtask

  initial begin
    int ph, n, len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, center, out-of-range axes, both stencils
    apply_config(3, 3, 3, MODE_CUBE26);
    send_coord(10'd1, 10'd1, 10'd1, 1'b1);
    send_coord(10'd0, 10'd0, 10'd0, 1'b0);
    send_coord(10'd2, 10'd2, 10'd2, 1'b0);
    send_coord(10'd3, 10'd0, 10'd0, 1'b0);
    send_coord(10'd0, 10'd0, 10'd3, 1'b1);
    apply_config(3, 3, 3, MODE_FACE6);
    send_coord(10'd1, 10'd1, 10'd1, 1'b1);
    send_coord(10'd0, 10'd0, 10'd0, 1'b0);
    send_coord(10'd2, 10'd1, 10'd0, 1'b0);
    send_coord(10'd0, 10'd3, 10'd0, 1'b0);
    // single-cell grid: no neighbors at all
    apply_config(1, 1, 1, MODE_FACE6);
    send_coord(10'd0, 10'd0, 10'd0, 1'b1);
    send_coord(10'd0, 10'd0, 10'd0, 1'b0);
    apply_config(1, 1, 1, MODE_CUBE26);
    send_coord(10'd0, 10'd0, 10'd0, 1'b0);
    // full-size grid and oversized dimensions that saturate
    apply_config(MAX_DIM_DEF, MAX_DIM_DEF, MAX_DIM_DEF, MODE_CUBE26);
    send_coord(10'd1023, 10'd1023, 10'd1023, 1'b1);
    send_coord(10'd0, 10'd0, 10'd0, 1'b0);
    send_coord(10'd512, 10'd1023, 10'd0, 1'b0);
    apply_config(2047, 2047, 2047, MODE_FACE6);
    send_coord(10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_coord(10'd1023, 10'd0, 10'd511, 1'b0);
    // empty grid: every coordinate is out of range; then an in-range cell of a thin grid
    apply_config(0, 5, 5, MODE_FACE6);
    send_coord(10'd0, 10'd0, 10'd0, 1'b1);
    apply_config(MAX_DIM_DEF, 1, 2, MODE_CUBE26);
    send_coord(10'd1023, 10'd0, 10'd1, 1'b0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      apply_config(pick_dim(), pick_dim(), pick_dim(), logic'($urandom_range(0, 1)));
      calm <= (ph == CALM_PHASE);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          send_coord(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                     COORD_W'($urandom_range(0, 1023)), logic'($urandom_range(0, 1)));
          n++;
        end else begin
          len = $urandom_range(2, 8);
          if (len > PHASE_ITEMS - n) len = PHASE_ITEMS - n;
          run_sweep(len);
          n += len;
        end
      end
    end
    calm <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d coordinates over %0d grid settings (both stencils, empty and capped",
             items_sent, n_settings);
    $display("grids); %0d neighbor transactions checked, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== grid_stencil_neighbor_generator.f =====
rtl/core/gsng_pkg.sv
rtl/core/gsng_regs.sv
rtl/core/gsng_ctrl.sv
rtl/core/gsng_dp.sv
rtl/core/grid_stencil_neighbor_generator.sv
rtl/core/gsng_checker.sv
tb/sv/gsng_neighbor_checker.sv
tb/sv/grid_stencil_neighbor_generator_test.sv
